// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL of the polar Gaussian generator.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gpsg_pkg.sv -----
// Package for the polar Gaussian generator: stage layout, constants and stage word type.
// No dependencies.
`default_nettype none

package gpsg_pkg;

  localparam int unsigned LogFrac    = 30;
  localparam int unsigned DivSteps   = 32;
  localparam int unsigned SqrtSteps  = 32;

  // Stage indexes along the pipeline.
  localparam int unsigned StSquare   = 1;
  localparam int unsigned StRadius   = 2;
  localparam int unsigned StLzd      = 3;
  localparam int unsigned StNorm     = 4;
  localparam int unsigned StLog0     = 5;
  localparam int unsigned StScale    = StLog0 + LogFrac;
  localparam int unsigned StDivInit  = StScale + 1;
  localparam int unsigned StDiv0     = StDivInit + 1;
  localparam int unsigned StProd     = StDiv0 + DivSteps;
  localparam int unsigned StSqrt0    = StProd + 1;
  localparam int unsigned StFinish   = StSqrt0 + SqrtSteps;
  localparam int unsigned NumStages  = StFinish + 1;

  // 2 ln 2 in Q.27
  localparam logic [27:0] TwoLn2Q27  = 28'hB17217F;
  localparam logic [63:0] RadiusOne  = 64'h4000_0000_0000_0000;
  localparam logic [32:0] SampleMax  = 33'h0_7FFF_FFFF;

  typedef struct packed {
    logic        neg1;
    logic        neg2;
    logic [63:0] a1;
    logic [63:0] a2;
    logic [63:0] den;
    logic [5:0]  k;
    logic [31:0] x;
    logic [29:0] f;
    logic [31:0] l;
    logic [32:0] q1;
    logic [32:0] q2;
    logic [63:0] r1;
    logic [63:0] r2;
  } stage_t;

endpackage

`default_nettype wire

// ----- rtl/gaussian_polar_sample_generator.sv -----
// Polar-method Gaussian generator top level: one pipeline plus a two-word output buffer.
// Depends on gpsg_pkg and assert_macros.svh.
`default_nettype none

// Each accepted pair of 32-bit uniforms either is dropped (outside the unit disc, or both at
// the center) or yields two Q5.27 samples, the second flagged by last_o. The datapath is a
// 103-stage pipeline (squares, radius, log2 by 30 squaring stages, 33 divide stages, 32 square
// root stages, round and saturate). A new pair can enter each cycle while the pipe is not
// halted; the single output channel moves one word per cycle while out_ready_i is high, so
// it limits sustained throughput. The whole pipe halts while the output buffer is full and
// the last stage holds a word pair.
module gaussian_polar_sample_generator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [31:0]        uniform_a_i,
  input  wire logic [31:0]        uniform_b_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic signed [31:0] sample_o,
  output      logic               last_o
);

  localparam int unsigned N = gpsg_pkg::NumStages;

  gpsg_pkg::stage_t stage_q [N];
  gpsg_pkg::stage_t stage_d [N];
  logic [N-1:0]     vld_q;
  logic [N-1:0]     vld_d;

  logic        pair_vld_q;
  logic        phase_q;
  logic [31:0] first_q;
  logic [31:0] second_q;

  logic buf_free;
  logic pipe_en;

  assign buf_free   = !pair_vld_q || (phase_q && out_ready_i);
  assign pipe_en    = buf_free || !vld_q[N-1];
  assign in_ready_o = pipe_en;

  for (genvar g = 0; g < N; g++) begin : g_stage
    if (g == 0) begin : g_in
      always_comb begin : p_in
        logic [32:0] ta;
        logic [32:0] tb;
        stage_d[g] = '0;
        ta = 33'h0_8000_0000 - {1'b0, uniform_a_i};
        tb = 33'h0_8000_0000 - {1'b0, uniform_b_i};
        stage_d[g].neg1 = !uniform_a_i[31];
        stage_d[g].neg2 = !uniform_b_i[31];
        stage_d[g].a1 = uniform_a_i[31] ? {33'd0, uniform_a_i[30:0]} : {32'd0, ta[31:0]};
        stage_d[g].a2 = uniform_b_i[31] ? {33'd0, uniform_b_i[30:0]} : {32'd0, tb[31:0]};
        vld_d[g] = in_valid_i;
      end
    end else if (g == gpsg_pkg::StSquare) begin : g_sq
      always_comb begin : p_sq
        stage_d[g] = stage_q[g-1];
        stage_d[g].a1 = {32'd0, stage_q[g-1].a1[31:0]} * {32'd0, stage_q[g-1].a1[31:0]};
        stage_d[g].a2 = {32'd0, stage_q[g-1].a2[31:0]} * {32'd0, stage_q[g-1].a2[31:0]};
        vld_d[g] = vld_q[g-1];
      end
    end else if (g == gpsg_pkg::StRadius) begin : g_rad
      always_comb begin : p_rad
        logic [63:0] r;
        r = stage_q[g-1].a1 + stage_q[g-1].a2;
        stage_d[g] = stage_q[g-1];
        stage_d[g].den = r;
        // drop pairs at the center or outside the unit disc
        vld_d[g] = vld_q[g-1] && (r != '0) && (r <= gpsg_pkg::RadiusOne);
      end
    end else if (g == gpsg_pkg::StLzd) begin : g_lzd
      always_comb begin : p_lzd
        logic [5:0] k;
        k = '0;
        for (int j = 0; j < 63; j++) begin
          if (stage_q[g-1].den[j]) k = 6'(j);
        end
        stage_d[g] = stage_q[g-1];
        stage_d[g].k = k;
        vld_d[g] = vld_q[g-1];
      end
    end else if (g == gpsg_pkg::StNorm) begin : g_norm
      always_comb begin : p_norm
        logic [63:0] sr;
        logic [63:0] sl;
        sr = stage_q[g-1].den >> (stage_q[g-1].k - 6'd31);
        sl = stage_q[g-1].den << (6'd31 - stage_q[g-1].k);
        stage_d[g] = stage_q[g-1];
        stage_d[g].x = (stage_q[g-1].k >= 6'd31) ? sr[31:0] : sl[31:0];
        stage_d[g].f = '0;
        vld_d[g] = vld_q[g-1];
      end
    end else if (g < gpsg_pkg::StScale) begin : g_log
      always_comb begin : p_log
        logic [63:0] sq;
        logic [32:0] t;
        sq = {32'd0, stage_q[g-1].x} * {32'd0, stage_q[g-1].x};
        t = sq[63:31];
        stage_d[g] = stage_q[g-1];
        stage_d[g].f = {stage_q[g-1].f[28:0], t[32]};
        stage_d[g].x = t[32] ? t[32:1] : t[31:0];
        vld_d[g] = vld_q[g-1];
      end
    end else if (g == gpsg_pkg::StScale) begin : g_scale
      always_comb begin : p_scale
        logic [35:0] nn;
        logic [63:0] prod;
        // -log2 r in Q.30, then times 2 ln 2 gives -2 ln r in Q.24
        nn = {6'd62 - stage_q[g-1].k, 30'd0} - {6'd0, stage_q[g-1].f};
        prod = {28'd0, nn} * {36'd0, gpsg_pkg::TwoLn2Q27};
        stage_d[g] = stage_q[g-1];
        stage_d[g].l = {1'b0, prod[63:33]};
        vld_d[g] = vld_q[g-1];
      end
    end else if (g == gpsg_pkg::StDivInit) begin : g_dinit
      always_comb begin : p_dinit
        logic ge1;
        logic ge2;
        ge1 = stage_q[g-1].a1 >= stage_q[g-1].den;
        ge2 = stage_q[g-1].a2 >= stage_q[g-1].den;
        stage_d[g] = stage_q[g-1];
        stage_d[g].q1 = {32'd0, ge1};
        stage_d[g].q2 = {32'd0, ge2};
        stage_d[g].a1 = ge1 ? stage_q[g-1].a1 - stage_q[g-1].den : stage_q[g-1].a1;
        stage_d[g].a2 = ge2 ? stage_q[g-1].a2 - stage_q[g-1].den : stage_q[g-1].a2;
        vld_d[g] = vld_q[g-1];
      end
    end else if (g < gpsg_pkg::StProd) begin : g_div
      always_comb begin : p_div
        logic [63:0] s1;
        logic [63:0] s2;
        logic        ge1;
        logic        ge2;
        s1 = {stage_q[g-1].a1[62:0], 1'b0};
        s2 = {stage_q[g-1].a2[62:0], 1'b0};
        ge1 = s1 >= stage_q[g-1].den;
        ge2 = s2 >= stage_q[g-1].den;
        stage_d[g] = stage_q[g-1];
        stage_d[g].a1 = ge1 ? s1 - stage_q[g-1].den : s1;
        stage_d[g].a2 = ge2 ? s2 - stage_q[g-1].den : s2;
        stage_d[g].q1 = {stage_q[g-1].q1[31:0], ge1};
        stage_d[g].q2 = {stage_q[g-1].q2[31:0], ge2};
        vld_d[g] = vld_q[g-1];
      end
    end else if (g == gpsg_pkg::StProd) begin : g_prod
      always_comb begin : p_prod
        stage_d[g] = stage_q[g-1];
        stage_d[g].a1 = 64'({31'd0, stage_q[g-1].q1} * {32'd0, stage_q[g-1].l});
        stage_d[g].a2 = 64'({31'd0, stage_q[g-1].q2} * {32'd0, stage_q[g-1].l});
        stage_d[g].r1 = '0;
        stage_d[g].r2 = '0;
        vld_d[g] = vld_q[g-1];
      end
    end else if (g < gpsg_pkg::StFinish) begin : g_sqrt
      localparam int unsigned BitPos = 62 - 2 * (g - gpsg_pkg::StSqrt0);
      always_comb begin : p_sqrt
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] b;
        b = 64'd1 << BitPos;
        t1 = stage_q[g-1].r1 + b;
        t2 = stage_q[g-1].r2 + b;
        stage_d[g] = stage_q[g-1];
        if (stage_q[g-1].a1 >= t1) begin
          stage_d[g].a1 = stage_q[g-1].a1 - t1;
          stage_d[g].r1 = (stage_q[g-1].r1 >> 1) + b;
        end else begin
          stage_d[g].r1 = stage_q[g-1].r1 >> 1;
        end
        if (stage_q[g-1].a2 >= t2) begin
          stage_d[g].a2 = stage_q[g-1].a2 - t2;
          stage_d[g].r2 = (stage_q[g-1].r2 >> 1) + b;
        end else begin
          stage_d[g].r2 = stage_q[g-1].r2 >> 1;
        end
        vld_d[g] = vld_q[g-1];
      end
    end else begin : g_fin
      always_comb begin : p_fin
        logic [32:0] m1;
        logic [32:0] m2;
        // Q.28 to Q.27, round half up, then saturate positive values and apply the sign
        m1 = ({1'b0, stage_q[g-1].r1[31:0]} + 33'd1) >> 1;
        m2 = ({1'b0, stage_q[g-1].r2[31:0]} + 33'd1) >> 1;
        if (!stage_q[g-1].neg1 && m1 > gpsg_pkg::SampleMax) m1 = gpsg_pkg::SampleMax;
        if (!stage_q[g-1].neg2 && m2 > gpsg_pkg::SampleMax) m2 = gpsg_pkg::SampleMax;
        stage_d[g] = stage_q[g-1];
        stage_d[g].a1 = {32'd0, stage_q[g-1].neg1 ? 32'd0 - m1[31:0] : m1[31:0]};
        stage_d[g].a2 = {32'd0, stage_q[g-1].neg2 ? 32'd0 - m2[31:0] : m2[31:0]};
        vld_d[g] = vld_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      stage_q <= stage_d;
    end
  end

  // output buffer: v2 sample first, then v1 sample with last set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_vld_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      if (pair_vld_q && out_ready_i) begin
        if (!phase_q) begin
          phase_q <= 1'b1;
        end else begin
          pair_vld_q <= 1'b0;
          phase_q    <= 1'b0;
        end
      end
      if (pipe_en && vld_q[N-1]) begin
        pair_vld_q <= 1'b1;
        phase_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en && vld_q[N-1]) begin
      first_q  <= stage_q[N-1].a2[31:0];
      second_q <= stage_q[N-1].a1[31:0];
    end
  end

  assign out_valid_o = pair_vld_q;
  assign sample_o    = phase_q ? second_q : first_q;
  assign last_o      = phase_q;

  `include "assert_macros.svh"

  `ASSERT_NEXT(a_second_follows, out_valid_o && out_ready_i && !last_o, out_valid_o && last_o, "second word missing after first")
  `ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(vld_q), "pipeline moved while stalled")
  `ASSERT_NEXT(a_load_starts, pipe_en && vld_q[N-1], pair_vld_q && !phase_q, "pair not loaded at phase zero")
  `ASSERT_CLK(a_stall_reason, !pipe_en |-> (pair_vld_q && vld_q[N-1]), "stall without full buffer")

endmodule

`default_nettype wire

// ----- tb/tb_gaussian_polar_sample_generator.sv -----
// Testbench for gaussian_polar_sample_generator: drives uniform pairs, predicts the polar
// Gaussian samples in fixed point and checks every output word. Needs only the RTL.
`default_nettype none

module tb_gaussian_polar_sample_generator;

  localparam int unsigned UniformBits = 32;
  localparam int unsigned FracBits    = 27;
  localparam int unsigned PipeDepth   = 120;
  localparam int unsigned StallLimit  = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [31:0]        uniform_a_i = '0;
  logic [31:0]        uniform_b_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] sample_o;
  logic               last_o;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } gauss_word_t;

  gauss_word_t expected_words[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          out_hold = 0;

  gaussian_polar_sample_generator uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // magnitude of 2u-1 in Q.31, with sign
  function automatic logic [63:0] half_offset_q31(input logic [31:0] u, output bit neg);
    logic [64:0] full, t, d;
    begin
      full = 65'd1 << UniformBits;
      t = ({33'd0, u} & (full - 1)) << 1;
      if (t >= full) begin
        d = t - full;
        neg = 1'b0;
      end else begin
        d = full - t;
        neg = 1'b1;
      end
      if (UniformBits >= 31) d = d >> (UniformBits - 31);
      else d = d << (31 - UniformBits);
      return d[63:0];
    end
  endfunction

  function automatic logic [63:0] minus_log2_q30(input logic [63:0] r);
    int          k;
    logic [63:0] x, f;
    logic [127:0] sq;
    begin
      k = 62;
      f = '0;
      while (k > 0 && r[k] == 1'b0) k--;
      if (k >= 31) x = r >> (k - 31);
      else x = r << (31 - k);
      for (int i = 0; i < 30; i++) begin
        sq = x * x;
        x = sq[94:31];
        f = f << 1;
        if (x >= (64'd1 << 32)) begin
          f[0] = 1'b1;
          x = x >> 1;
        end
      end
      return (64'(62 - k) << 30) - f;
    end
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, b;
    begin
      res = '0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else res = res >> 1;
        b = b >> 2;
      end
      return res;
    end
  endfunction

  function automatic logic [31:0] gauss_sample(input logic [63:0] m, input bit neg,
                                               input logic [63:0] r, input logic [63:0] l);
    logic [127:0] num;
    logic [63:0]  q, mag, lim;
    begin
      num = ({64'd0, m * m}) << 32;
      q = 64'(num / r);
      mag = int_sqrt(q * l);
      if (FracBits < 28) mag = (mag + (64'd1 << (27 - FracBits))) >> (28 - FracBits);
      else mag = mag << (FracBits - 28);
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (mag > lim) mag = lim;
      if (neg) mag = -mag;
      return mag[31:0];
    end
  endfunction

  task automatic predict_pair(input logic [31:0] ua, input logic [31:0] ub);
    bit          n1, n2;
    logic [63:0] m1, m2, r, l;
    logic [127:0] prod;
    begin
      m1 = half_offset_q31(ua, n1);
      m2 = half_offset_q31(ub, n2);
      r = m1 * m1 + m2 * m2;
      if (r == 0 || r > (64'd1 << 62)) return;
      prod = minus_log2_q30(r) * 128'h0B17217F;
      l = prod[96:33];
      expected_words.push_back('{gauss_sample(m2, n2, r, l), 1'b0});
      expected_words.push_back('{gauss_sample(m1, n1, r, l), 1'b1});
    end
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 9) < 8) ?
      $urandom_range(1, 3) : $urandom_range(10, 40));
  endfunction

  bit quiet_phase = 1'b0;

  // valid stays high between back-to-back words and drops only for a gap
  task automatic send_pair(input logic [31:0] ua, input logic [31:0] ub);
    int g;
    begin
      g = quiet_phase ? 0 : gap_len();
      if (g != 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      uniform_a_i <= ua;
      uniform_b_i <= ub;
      in_valid_i  <= 1'b1;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      predict_pair(ua, ub);
      @(negedge clk_i);
    end
  endtask

  // output side: random back-pressure runs, check at rising edge
  always @(negedge clk_i) begin
    int g;
    if (rst_ni) begin
      if (quiet_phase) begin
        out_ready_i <= 1'b1;
        out_hold    <= 0;
      end else if (out_hold != 0) begin
        out_ready_i <= 1'b0;
        out_hold    <= out_hold - 1;
      end else begin
        g = gap_len();
        out_ready_i <= (g == 0);
        out_hold    <= (g == 0) ? 0 : g - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    gauss_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word sample=%h last=%b", $time, sample_o, last_o);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (sample_o !== want.sample) begin
          $display("%0t: sample expected %h actual %h", $time, want.sample, sample_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("gaussian_polar_sample_generator: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    begin
      send_pair(32'h0000_0000, 32'h0000_0000);  // corner, outside disc
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(32'h8000_0000, 32'h8000_0000);  // zero pair
      send_pair(32'h0000_0000, 32'h8000_0000);  // unit circle
      send_pair(32'h8000_0000, 32'h0000_0000);
      send_pair(32'hC000_0000, 32'h8000_0000);
      send_pair(32'h8000_0001, 32'h8000_0000);  // tiny radius, largest sample
      send_pair(32'h7FFF_FFFF, 32'h8000_0000);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF);
      send_pair(32'h8000_0001, 32'h8000_0001);
      send_pair(32'h4000_0000, 32'h4000_0000);
      send_pair(32'hB504_F334, 32'hB504_F334);
      send_pair(32'h2000_0000, 32'hE000_0000);
      send_pair(32'h5555_5555, 32'hAAAA_AAAA);
      send_pair(32'h0000_0001, 32'h8000_0000);
      send_pair(32'hFFFF_FFFF, 32'h8000_0000);
    end
  endtask

  task automatic test_random();
    logic [31:0] a, b;
    begin
      for (int i = 0; i < 400; i++) begin
        if (i == 150) quiet_phase = 1'b1;
        if (i == 230) quiet_phase = 1'b0;
        a = $urandom();
        b = $urandom();
        // near the center now and then to reach large samples
        if ($urandom_range(0, 9) == 0) begin
          a = 32'h8000_0000 + $urandom_range(0, 65535) - 32768;
          b = 32'h8000_0000 + $urandom_range(0, 65535) - 32768;
        end
        send_pair(a, b);
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
    if (errors == 0 && expected_words.size() == 0)
      $display("gaussian_polar_sample_generator: match");
    else
      $display("gaussian_polar_sample_generator: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
